### design/bsc_pkg.sv
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared types and constants for the clipped 3x3 box smoothing unit.
// ----------------------------------------------------------------------------
package bsc_pkg;

  localparam int MAX_DIM  = 16;
  localparam int DIM_W    = $clog2(MAX_DIM);
  localparam int SIZE_W   = 5;
  localparam int PIX_W    = 8;
  localparam int WIN_N    = 9;
  localparam int SUM_W    = 12;

  // reciprocal multiply for the three clipped window sizes
  localparam int RECIP_SHIFT = 18;
  localparam int RECIP_W     = 17;
  localparam logic [RECIP_W-1:0] RECIP_DIV4 = RECIP_W'((1 << RECIP_SHIFT) / 4);
  localparam logic [RECIP_W-1:0] RECIP_DIV6 = RECIP_W'(((1 << RECIP_SHIFT) + 5) / 6);
  localparam logic [RECIP_W-1:0] RECIP_DIV9 = RECIP_W'(((1 << RECIP_SHIFT) + 8) / 9);
  localparam int PROD_W = SUM_W + RECIP_W;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(MAX_DIM);

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [DIM_W-1:0] pos_t;

  // window snapshot after insertion, index is column_slot * 3 + row_slot, slot 0 oldest
  typedef struct packed {
    logic [WIN_N-1:0][PIX_W-1:0] pix;
    pos_t                        ri;
    pos_t                        ci;
    pos_t                        nm1;
  } job_t;

endpackage

### design/bsc_window.sv
// ----------------------------------------------------------------------------
// bsc_window
// Frame position counters, two line stores and the 3x3 window shift.
// ----------------------------------------------------------------------------
module bsc_window (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [bsc_pkg::SIZE_W-1:0] cfg_wr_data,
  input  logic                      accept,
  input  bsc_pkg::pix_t             pixel,
  output bsc_pkg::job_t             job,
  output logic                      job_has
);
  import bsc_pkg::*;

  logic [SIZE_W-1:0]          size_r;
  pos_t                       row_r, row_nxt;
  pos_t                       col_r, col_nxt;
  logic [WIN_N-1:0][PIX_W-1:0] win_r, win_nxt;
  pix_t                       line_above_r [MAX_DIM];
  pix_t                       line_prev_r  [MAX_DIM];
  pos_t                       nm1;
  pos_t                       rd_addr;
  pix_t                       above_rd_r, prev_rd_r;

  always_comb begin
    if (size_r < SIZE_W'(2)) begin
      nm1 = DIM_W'(1);
    end else if (size_r > SIZE_W'(MAX_DIM)) begin
      nm1 = DIM_W'(MAX_DIM - 1);
    end else begin
      nm1 = DIM_W'(size_r - SIZE_W'(1));
    end
  end

  always_comb begin
    win_nxt = win_r;
    for (int i = 0; i < WIN_N - 3; i++) begin
      win_nxt[i] = win_r[i+3];
    end
    win_nxt[WIN_N-3] = above_rd_r;
    win_nxt[WIN_N-2] = prev_rd_r;
    win_nxt[WIN_N-1] = pixel;
  end

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r + DIM_W'(1);
    if (col_r == nm1) begin
      col_nxt = '0;
      row_nxt = (row_r == nm1) ? '0 : row_r + DIM_W'(1);
    end
  end

  // line store read address tracks the column of the next transaction
  always_comb begin
    if (!rst_n || cfg_wr_en) begin
      rd_addr = '0;
    end else if (accept) begin
      rd_addr = col_nxt;
    end else begin
      rd_addr = col_r;
    end
  end

  assign job.pix = win_nxt;
  assign job.ri  = row_r;
  assign job.ci  = col_r;
  assign job.nm1 = nm1;
  assign job_has = (row_r != '0) && (col_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SIZE_RESET;
      row_r  <= '0;
      col_r  <= '0;
      win_r  <= '0;
    end else if (cfg_wr_en) begin
      size_r <= cfg_wr_data;
      row_r  <= '0;
      col_r  <= '0;
    end else if (accept) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
      win_r <= win_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !cfg_wr_en) begin
      line_above_r[col_r] <= prev_rd_r;
      line_prev_r[col_r]  <= pixel;
    end
    above_rd_r <= line_above_r[rd_addr];
    prev_rd_r  <= line_prev_r[rd_addr];
  end

endmodule

### design/bsc_mean.sv
// ----------------------------------------------------------------------------
// bsc_mean
// Clipped window sum and truncated mean by reciprocal multiply.
// ----------------------------------------------------------------------------
module bsc_mean (
  input  bsc_pkg::job_t job,
  input  logic          dr,
  input  logic          dc,
  output bsc_pkg::pix_t smoothed
);
  import bsc_pkg::*;

  logic [2:0]         row_en, col_en;
  logic [SUM_W-1:0]   sum;
  logic [RECIP_W-1:0] recip;
  logic [PROD_W-1:0]  prod;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      row_en[j] = (2'(j) >= {1'b0, dr}) && (({1'b0, job.ri} + 5'(j)) >= 5'd2);
      col_en[j] = (2'(j) >= {1'b0, dc}) && (({1'b0, job.ci} + 5'(j)) >= 5'd2);
    end
  end

  always_comb begin
    sum = '0;
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        if (row_en[j] && col_en[k]) begin
          sum = sum + SUM_W'(job.pix[k*3+j]);
        end
      end
    end
  end

  always_comb begin
    if (&row_en && &col_en) begin
      recip = RECIP_DIV9;
    end else if (&row_en || &col_en) begin
      recip = RECIP_DIV6;
    end else begin
      recip = RECIP_DIV4;
    end
  end

  assign prod     = PROD_W'(sum) * PROD_W'(recip);
  assign smoothed = prod[RECIP_SHIFT +: PIX_W];

endmodule

### design/bsc_emit.sv
// ----------------------------------------------------------------------------
// bsc_emit
// Job register, result sequencing and the output register.
// ----------------------------------------------------------------------------
module bsc_emit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  bsc_pkg::job_t job_in,
  input  logic          job_has,
  output logic          busy,
  output logic          out_valid,
  input  logic          out_stall,
  output bsc_pkg::pos_t out_row,
  output bsc_pkg::pos_t out_col,
  output bsc_pkg::pix_t out_smoothed,
  output logic          out_last_of_run,
  output logic          out_frame_done
);
  import bsc_pkg::*;

  job_t  job_r;
  logic  job_valid_r;
  logic  dr_r, dc_r;
  logic  ext_r, ext_c;
  logic  cur_last;
  logic  out_load, job_load;
  pos_t  cur_row, cur_col;
  pix_t  mean;
  logic  out_valid_r;
  pos_t  row_r, col_r;
  pix_t  smoothed_r;
  logic  last_r, done_r;

  bsc_mean u_mean (
    .job      (job_r),
    .dr       (dr_r),
    .dc       (dc_r),
    .smoothed (mean)
  );

  assign ext_c    = (job_r.ci == job_r.nm1);
  assign ext_r    = (job_r.ri == job_r.nm1);
  assign cur_last = !((!dc_r && ext_c) || (!dr_r && ext_r));
  assign cur_row  = dr_r ? job_r.ri : job_r.ri - DIM_W'(1);
  assign cur_col  = dc_r ? job_r.ci : job_r.ci - DIM_W'(1);

  assign out_load = job_valid_r && (!out_valid_r || !out_stall);
  assign busy     = job_valid_r && !(out_load && cur_last);
  assign job_load = accept && job_has;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
    end else if (job_load) begin
      job_valid_r <= 1'b1;
    end else if (out_load && cur_last) begin
      job_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (job_load) begin
      job_r <= job_in;
      dr_r  <= 1'b0;
      dc_r  <= 1'b0;
    end else if (out_load && !cur_last) begin
      if (!dc_r && ext_c) begin
        dc_r <= 1'b1;
      end else begin
        dr_r <= 1'b1;
        dc_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      row_r      <= cur_row;
      col_r      <= cur_col;
      smoothed_r <= mean;
      last_r     <= cur_last;
      done_r     <= (cur_row == job_r.nm1) && (cur_col == job_r.nm1);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_row         = row_r;
  assign out_col         = col_r;
  assign out_smoothed    = smoothed_r;
  assign out_last_of_run = last_r;
  assign out_frame_done  = done_r;

  // a new job only lands on an empty or retiring job register
  a_job_free: assert property (@(posedge clk) disable iff (!rst_n)
    job_load |-> (!job_valid_r || (out_load && cur_last)))
    else $error("job register overwritten");

  // second row of a run only exists on the bottom frame row
  a_row_step: assert property (@(posedge clk) disable iff (!rst_n)
    (job_valid_r && dr_r) |-> ext_r)
    else $error("row step outside bottom row");

  // frame end is always the last transaction of its run
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && done_r) |-> last_r)
    else $error("frame end not last of run");

  // a held job keeps its sequence position
  a_job_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (job_valid_r && !out_load && !job_load) |=> (job_valid_r && $stable(dr_r) && $stable(dc_r)))
    else $error("job moved while stalled");

endmodule

### design/box_smooth_3x3_clipped_unit.sv
// ----------------------------------------------------------------------------
// box_smooth_3x3_clipped_unit
// Streaming clipped 3x3 mean filter over a square raster frame.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  in_pixel
//   out      output     out_valid/out_stall  out_row, out_col, out_smoothed,
//                                            out_last_of_run, out_frame_done
//   cfg      input      cfg_wr_en            cfg_wr_data (image size)
//
// One pixel per cycle is taken; a pixel that completes k results stalls the
// input until all but its last are loaded by the single mean unit feeding
// the output register. A first result passes the job then output register.
// Reset selects a 16x16 frame and clears the window and position counters.
// Output stalls back up through the job register into in_stall.
// ----------------------------------------------------------------------------
module box_smooth_3x3_clipped_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [bsc_pkg::SIZE_W-1:0] cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  bsc_pkg::pix_t              in_pixel,
  output logic                       out_valid,
  input  logic                       out_stall,
  output bsc_pkg::pos_t              out_row,
  output bsc_pkg::pos_t              out_col,
  output bsc_pkg::pix_t              out_smoothed,
  output logic                       out_last_of_run,
  output logic                       out_frame_done
);
  import bsc_pkg::*;

  job_t job;
  logic job_has;
  logic busy;
  logic accept;

  assign in_stall = busy;
  assign accept   = in_valid && !busy;

  bsc_window u_window (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .accept      (accept),
    .pixel       (in_pixel),
    .job         (job),
    .job_has     (job_has)
  );

  bsc_emit u_emit (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (accept),
    .job_in          (job),
    .job_has         (job_has),
    .busy            (busy),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_row         (out_row),
    .out_col         (out_col),
    .out_smoothed    (out_smoothed),
    .out_last_of_run (out_last_of_run),
    .out_frame_done  (out_frame_done)
  );

endmodule
